// ===== rtl/piecewise_polynomial_trajectory_eval_unit_macros.svh =====
// Assertion macros for the trajectory evaluator
`ifndef PIECEWISE_POLYNOMIAL_TRAJECTORY_EVAL_UNIT_MACROS_SVH
`define PIECEWISE_POLYNOMIAL_TRAJECTORY_EVAL_UNIT_MACROS_SVH
// implication checked on every clock, idle during reset
`define PPT_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define PPT_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== rtl/ppt_pkg.sv =====
// Package: constants, types and helpers for the trajectory evaluator
package ppt_pkg;
   localparam int MaxSegments = 16;
   localparam int NumCoeffs   = 6;
   localparam int NumDerivs   = 3;
   localparam int NumAxes     = 3;
   localparam int SegW        = $clog2(MaxSegments);
   localparam int CntW        = $clog2(MaxSegments + 1);
   localparam int CoefDepth   = MaxSegments * NumCoeffs * NumAxes;
   localparam int CoefAw      = $clog2(CoefDepth);
   localparam int PowW        = $clog2(NumCoeffs);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_WRITE  = 2'd2,
      OP_EVAL   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_POWER,
      ST_TERM,
      ST_SUM,
      ST_DONE
   } state_type;

   function automatic logic [4:0] deriv_weight(input logic [2:0] k, input logic [1:0] d);
      logic [4:0] w;
      w = 5'd1;
      case (d)
         2'd1: w = 5'(k);
         2'd2: w = 5'(k * (k - 3'd1));
         default: w = 5'd1;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// ===== rtl/ppt_ram.sv =====
// Generic RAM with one write port and one read port, registered read
module ppt_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/piecewise_polynomial_trajectory_eval_unit.sv =====
// Top level: piecewise polynomial trajectory evaluator
// channel | ports            | handshake
// request | req_*            | start high, busy low
// result  | rsp_*            | rsp_valid one cycle, no backpressure
// Clear, append and write complete without going busy; no result.
// Evaluate (empty table: straight to done) stays busy through a scan of segment end times,
// 5 power products, 45 terms on one shared 33x33 multiplier, 9 sums and a done state.
// Reset clears the state, the segment count and rsp_valid only; stores are undefined until written.
// The receiver cannot stall.
`include "piecewise_polynomial_trajectory_eval_unit_macros.svh"
module piecewise_polynomial_trajectory_eval_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_segment_index,
   input  logic [2:0]  req_power_index,
   input  logic [1:0]  req_axis_index,
   input  logic signed [31:0] req_coeff_value,
   input  logic [31:0] req_time_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z,
   output logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z,
   output logic signed [31:0] rsp_acc_x, rsp_acc_y, rsp_acc_z,
   output logic        rsp_empty_table
);
   localparam int SW = ppt_pkg::SegW;
   localparam int CW = ppt_pkg::CntW;
   localparam int AW = ppt_pkg::CoefAw;

   ppt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   last_end_ff, last_end_in;
   logic [31:0]   t_ff, t_in;
   logic [31:0]   prev_end_ff, prev_end_in;
   logic [SW-1:0] seg_ff, seg_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          rd_wait_ff, rd_wait_in;
   logic [31:0]   pw_ff [ppt_pkg::NumCoeffs];
   logic [31:0]   pw_in [ppt_pkg::NumCoeffs];
   logic [2:0]    k_ff, k_in;
   logic [1:0]    d_ff, d_in;
   logic [1:0]    a_ff, a_in;
   logic [1:0]    ph_ff, ph_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0]   res_ff [9];
   logic [31:0]   res_in [9];
   logic          valid_ff, valid_in, empty_ff, empty_in;

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != ppt_pkg::ST_IDLE);

   // end-time memory
   logic          te_wr;
   logic [SW-1:0] te_wa, te_ra;
   logic [31:0]   te_wd, te_rd;
   logic [32:0]   sum_end;
   assign sum_end = {1'b0, (count_ff == '0) ? 32'd0 : last_end_ff} + {1'b0, req_time_value};
   assign te_wr = accept && req_operation == ppt_pkg::OP_APPEND
                  && count_ff < CW'(ppt_pkg::MaxSegments);
   assign te_wa = count_ff[SW-1:0];
   assign te_wd = sum_end[32] ? 32'hFFFF_FFFF : sum_end[31:0];
   assign te_ra = scan_ff[SW-1:0];
   ppt_ram #(.Width(32), .Depth(ppt_pkg::MaxSegments)) u_ends (
      .clock(clock), .wr_en(te_wr), .wr_addr(te_wa), .wr_data(te_wd),
      .rd_addr(te_ra), .rd_data(te_rd));

   // coefficient memory
   logic          cf_wr;
   logic [AW-1:0] cf_wa, cf_ra;
   logic [31:0]   cf_rd;
   assign cf_wr = accept && req_operation == ppt_pkg::OP_WRITE
                  && 32'(req_segment_index) < 32'(ppt_pkg::MaxSegments)
                  && 32'(req_power_index) < 32'(ppt_pkg::NumCoeffs)
                  && req_axis_index != 2'd3;
   assign cf_wa = AW'((32'(req_segment_index) * ppt_pkg::NumCoeffs + 32'(req_power_index))
                      * ppt_pkg::NumAxes + 32'(req_axis_index));
   assign cf_ra = AW'((32'(seg_ff) * ppt_pkg::NumCoeffs + 32'(k_ff)) * ppt_pkg::NumAxes
                      + 32'(a_ff));
   ppt_ram #(.Width(32), .Depth(ppt_pkg::CoefDepth)) u_coef (
      .clock(clock), .wr_en(cf_wr), .wr_addr(cf_wa), .wr_data(req_coeff_value),
      .rd_addr(cf_ra), .rd_data(cf_rd));

   // shared multiplier
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic [31:0] tau;
   assign tau = t_ff - prev_end_ff;
   always_comb begin
      if (state_ff == ppt_pkg::ST_POWER) begin
         mul_a = {1'b0, pw_ff[k_ff - 3'd1]};
         mul_b = {1'b0, tau};
      end else begin
         mul_a = {cf_rd[31], cf_rd};
         mul_b = {1'b0, pw_ff[k_ff - 3'(d_ff)]};
      end
   end
   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppt_pkg::ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      last_end_ff <= last_end_in; t_ff <= t_in; prev_end_ff <= prev_end_in;
      seg_ff <= seg_in; scan_ff <= scan_in; rd_wait_ff <= rd_wait_in;
      pw_ff <= pw_in; k_ff <= k_in; d_ff <= d_in; a_ff <= a_in; ph_ff <= ph_in;
      acc_ff <= acc_in; prod_ff <= prod_in; res_ff <= res_in; empty_ff <= empty_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppt_pkg::ST_IDLE:
            if (accept && req_operation == ppt_pkg::OP_EVAL)
               state_in = (count_ff == '0) ? ppt_pkg::ST_DONE : ppt_pkg::ST_SEARCH;
         ppt_pkg::ST_SEARCH:
            if (rd_wait_ff && (t_ff <= te_rd || scan_ff == count_ff - CW'(1)))
               state_in = ppt_pkg::ST_POWER;
         ppt_pkg::ST_POWER:
            if (k_ff == 3'(ppt_pkg::NumCoeffs - 1)) state_in = ppt_pkg::ST_TERM;
         ppt_pkg::ST_TERM:
            if (ph_ff == 2'd2 && k_ff == 3'(ppt_pkg::NumCoeffs - 1)) state_in = ppt_pkg::ST_SUM;
         ppt_pkg::ST_SUM:
            if (a_ff == 2'd2 && d_ff == 2'(ppt_pkg::NumDerivs - 1)) state_in = ppt_pkg::ST_DONE;
            else state_in = ppt_pkg::ST_TERM;
         ppt_pkg::ST_DONE: state_in = ppt_pkg::ST_IDLE;
         default: state_in = ppt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      logic [47:0] pwide;
      count_in = count_ff; last_end_in = last_end_ff; t_in = t_ff;
      prev_end_in = prev_end_ff; seg_in = seg_ff; scan_in = scan_ff;
      rd_wait_in = 1'b0; pw_in = pw_ff; k_in = k_ff; d_in = d_ff; a_in = a_ff;
      ph_in = ph_ff; acc_in = acc_ff; prod_in = prod_ff; res_in = res_ff;
      valid_in = 1'b0; empty_in = empty_ff;
      pwide = mul_p[63:16];
      case (state_ff)
         ppt_pkg::ST_IDLE: if (accept) begin
            case (req_operation)
               ppt_pkg::OP_CLEAR: count_in = '0;
               ppt_pkg::OP_APPEND: if (te_wr) begin
                  count_in = count_ff + CW'(1);
                  last_end_in = te_wd;
               end
               ppt_pkg::OP_EVAL: begin
                  t_in = (req_time_value > last_end_ff) ? last_end_ff : req_time_value;
                  scan_in = '0; prev_end_in = '0; empty_in = (count_ff == '0);
                  for (int j = 0; j < 9; j++) res_in[j] = '0;
               end
               default: ;
            endcase
         end
         ppt_pkg::ST_SEARCH: begin
            rd_wait_in = !rd_wait_ff;
            if (rd_wait_ff) begin
               seg_in = scan_ff[SW-1:0];
               if (!(t_ff <= te_rd || scan_ff == count_ff - CW'(1))) begin
                  prev_end_in = te_rd;
                  scan_in = scan_ff + CW'(1);
               end else begin
                  pw_in[0] = 32'h0001_0000; k_in = 3'd1;
               end
            end
         end
         ppt_pkg::ST_POWER: begin
            pw_in[k_ff] = (mul_p[65:48] != '0) ? 32'hFFFF_FFFF : pwide[31:0];
            if (k_ff == 3'(ppt_pkg::NumCoeffs - 1)) begin
               d_in = '0; a_in = '0; k_in = '0; ph_in = '0; acc_in = '0;
               if (t_ff < prev_end_ff) begin
                  for (int j = 1; j < ppt_pkg::NumCoeffs; j++) pw_in[j] = '0;
               end
            end else k_in = k_ff + 3'd1;
         end
         ppt_pkg::ST_TERM: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd1) prod_in = 64'(mul_p >>> 16);
            if (ph_ff == 2'd2) begin
               acc_in = acc_ff + prod_ff * $signed({1'b0, ppt_pkg::deriv_weight(k_ff, d_ff)});
               ph_in = '0;
               if (k_ff != 3'(ppt_pkg::NumCoeffs - 1)) k_in = k_ff + 3'd1;
            end
         end
         ppt_pkg::ST_SUM: begin
            res_in[4'(d_ff) * 4'd3 + 4'(a_ff)] = ppt_pkg::sat32(acc_ff);
            acc_in = '0; ph_in = '0;
            if (a_ff == 2'd2) begin a_in = '0; d_in = d_ff + 2'd1; k_in = 3'(d_ff + 2'd1); end
            else begin a_in = a_ff + 2'd1; k_in = 3'(d_ff); end
         end
         ppt_pkg::ST_DONE: valid_in = 1'b1;
         default: ;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_pos_x = res_ff[0]; assign rsp_pos_y = res_ff[1]; assign rsp_pos_z = res_ff[2];
   assign rsp_vel_x = res_ff[3]; assign rsp_vel_y = res_ff[4]; assign rsp_vel_z = res_ff[5];
   assign rsp_acc_x = res_ff[6]; assign rsp_acc_y = res_ff[7]; assign rsp_acc_z = res_ff[8];
   assign rsp_empty_table = empty_ff;

   `PPT_ASSERT_NEXT(a_eval_busy, clock, reset, accept && req_operation == ppt_pkg::OP_EVAL, busy, "evaluate did not go busy")
   `PPT_ASSERT_NEXT(a_one_pulse, clock, reset, rsp_valid, !rsp_valid, "result held over two cycles")
   `PPT_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(ppt_pkg::MaxSegments), "segment count overflow")
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the piecewise polynomial trajectory evaluator
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int NumVals = 9;

   typedef struct {
      logic signed [31:0] vals[NumVals];
      logic               empty;
   } motion_sample_type;

   class trajectory_scoreboard_type;
      logic [31:0]        end_times[ppt_pkg::MaxSegments];
      int                 seg_count;
      logic signed [31:0] coeffs[ppt_pkg::MaxSegments][ppt_pkg::NumCoeffs][ppt_pkg::NumAxes];
      motion_sample_type  expected_samples[$];
      int                 mismatches;

      function void clear_state();
         seg_count = 0;
         mismatches = 0;
         expected_samples.delete();
      endfunction

      function logic [31:0] sat_to_q16(longint v);
         logic [31:0] r;
         if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
         else if (v < -64'sd2147483648) r = 32'h8000_0000;
         else r = v[31:0];
         return r;
      endfunction

      function motion_sample_type predict_motion(logic [31:0] query);
         motion_sample_type s;
         logic [31:0] t, seg_start, tau;
         longint unsigned pw[ppt_pkg::NumCoeffs];
         longint unsigned p;
         longint acc, w, prod;
         int seg;
         s.empty = 1'b0;
         t = query;
         if (t > end_times[seg_count - 1]) t = end_times[seg_count - 1];
         seg = seg_count - 1;
         for (int i = seg_count - 1; i >= 0; i--)
            if (t <= end_times[i]) seg = i;
         seg_start = (seg == 0) ? 32'd0 : end_times[seg - 1];
         tau = (t >= seg_start) ? t - seg_start : 32'd0;
         pw[0] = 64'd65536;
         for (int k = 1; k < ppt_pkg::NumCoeffs; k++) begin
            p = (pw[k - 1] * longint'({32'd0, tau})) >> 16;
            pw[k] = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
         end
         for (int d = 0; d < 3; d++) begin
            for (int a = 0; a < ppt_pkg::NumAxes; a++) begin
               acc = 0;
               if (d < ppt_pkg::NumDerivs) begin
                  for (int k = d; k < ppt_pkg::NumCoeffs; k++) begin
                     w = 1;
                     for (int j = 0; j < d; j++) w = w * (k - j);
                     prod = longint'(coeffs[seg][k][a]) * longint'(pw[k - d]);
                     acc = acc + (prod >>> 16) * w;
                  end
               end
               s.vals[d * ppt_pkg::NumAxes + a] = sat_to_q16(acc);
            end
         end
         return s;
      endfunction

      function void note_request(ppt_pkg::op_type op, logic [3:0] sidx, logic [2:0] pidx,
                                 logic [1:0] aidx, logic [31:0] cval, logic [31:0] tval);
         motion_sample_type s;
         longint unsigned e;
         case (op)
            ppt_pkg::OP_CLEAR: seg_count = 0;
            ppt_pkg::OP_APPEND: begin
               if (seg_count < ppt_pkg::MaxSegments) begin
                  e = (seg_count == 0) ? 0 : end_times[seg_count - 1];
                  e = e + tval;
                  end_times[seg_count] = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
                  seg_count++;
               end
            end
            ppt_pkg::OP_WRITE: begin
               if (pidx < ppt_pkg::NumCoeffs && aidx < ppt_pkg::NumAxes)
                  coeffs[sidx][pidx][aidx] = cval;
            end
            default: begin
               if (seg_count == 0) begin
                  foreach (s.vals[i]) s.vals[i] = '0;
                  s.empty = 1'b1;
               end else begin
                  s = predict_motion(tval);
               end
               expected_samples = {expected_samples, s};
            end
         endcase
      endfunction

      function void check_result(motion_sample_type got);
         motion_sample_type want;
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            return;
         end
         want = expected_samples.pop_front();
         for (int i = 0; i < NumVals; i++) begin
            if (got.vals[i] !== want.vals[i]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("value %0d: expected %h got %h at %0t",
                           i, want.vals[i], got.vals[i], $realtime);
            end
         end
         if (got.empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
               $display("empty_table: expected %b got %b at %0t", want.empty, got.empty,
                        $realtime);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [3:0]  req_segment_index;
   logic [2:0]  req_power_index;
   logic [1:0]  req_axis_index;
   logic signed [31:0] req_coeff_value;
   logic [31:0] req_time_value;
   logic        rsp_valid;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic signed [31:0] rsp_acc_x, rsp_acc_y, rsp_acc_z;
   logic        rsp_empty_table;

   trajectory_scoreboard_type motion_board;
   int idle_pct;
   int request_count;
   int quiet_cycles = 0;

   piecewise_polynomial_trajectory_eval_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_segment_index(req_segment_index),
      .req_power_index(req_power_index), .req_axis_index(req_axis_index),
      .req_coeff_value(req_coeff_value), .req_time_value(req_time_value),
      .rsp_valid(rsp_valid),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y), .rsp_vel_z(rsp_vel_z),
      .rsp_acc_x(rsp_acc_x), .rsp_acc_y(rsp_acc_y), .rsp_acc_z(rsp_acc_z),
      .rsp_empty_table(rsp_empty_table)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      motion_sample_type got;
      if (!reset) begin
         if (start && !busy)
            motion_board.note_request(ppt_pkg::op_type'(req_operation), req_segment_index,
                                      req_power_index, req_axis_index, req_coeff_value,
                                      req_time_value);
         if (rsp_valid) begin
            got.vals = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z,
                         rsp_acc_x, rsp_acc_y, rsp_acc_z};
            got.empty = rsp_empty_table;
            motion_board.check_result(got);
         end
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else if (quiet_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end else quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(ppt_pkg::op_type op, logic [3:0] sidx, logic [2:0] pidx,
                               logic [1:0] aidx, logic [31:0] cval, logic [31:0] tval);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_segment_index <= sidx;
      req_power_index <= pidx;
      req_axis_index <= aidx;
      req_coeff_value <= cval;
      req_time_value <= tval;
      do @(posedge clock); while (busy);
      request_count++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (motion_board.expected_samples.size() != 0);
   endtask

   function automatic logic [31:0] pick_duration();
      case ($urandom_range(11))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(32'h0004_0000, 1);
      endcase
   endfunction

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_query();
      int n;
      n = motion_board.seg_count;
      if (n == 0) return $urandom;
      case ($urandom_range(7))
         0: return 32'd0;
         1: return motion_board.end_times[n - 1];
         2: return $urandom;
         3: return motion_board.end_times[$urandom_range(n - 1)];
         4: return motion_board.end_times[$urandom_range(n - 1)] + 32'd1;
         default: return $urandom_range(motion_board.end_times[n - 1]);
      endcase
   endfunction

   task automatic run_trajectory();
      int nseg;
      if ($urandom_range(9) != 0)
         send_request(ppt_pkg::OP_CLEAR, 4'($urandom), 3'($urandom), 2'($urandom),
                      $urandom, $urandom);
      nseg = ($urandom_range(9) == 0) ? $urandom_range(18, 12) : $urandom_range(4, 1);
      repeat (nseg) send_request(ppt_pkg::OP_APPEND, 4'($urandom), 3'($urandom),
                                 2'($urandom), $urandom, pick_duration());
      repeat ($urandom_range(8)) begin
         if ($urandom_range(9) == 0)
            send_request(ppt_pkg::OP_WRITE, 4'($urandom), 3'($urandom), 2'($urandom),
                         pick_coeff(), $urandom);
         else
            send_request(ppt_pkg::OP_WRITE, 4'($urandom_range(motion_board.seg_count > 0 ?
                         motion_board.seg_count - 1 : 0)),
                         3'($urandom_range(ppt_pkg::NumCoeffs - 1)),
                         2'($urandom_range(ppt_pkg::NumAxes - 1)), pick_coeff(), $urandom);
      end
      repeat ($urandom_range(5, 1)) begin
         if ($urandom_range(9) == 0)
            send_request(ppt_pkg::op_type'($urandom_range(3)), 4'($urandom), 3'($urandom),
                         2'($urandom), $urandom, $urandom);
         else
            send_request(ppt_pkg::OP_EVAL, 4'($urandom), 3'($urandom), 2'($urandom),
                         $urandom, pick_query());
      end
   endtask

   initial begin
      motion_board = new();
      motion_board.clear_state();
      request_count = 0;
      idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= ppt_pkg::OP_CLEAR;
      req_segment_index <= '0;
      req_power_index <= '0;
      req_axis_index <= '0;
      req_coeff_value <= '0;
      req_time_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the coefficient store so no evaluate reads an unwritten entry
      for (int s = 0; s < ppt_pkg::MaxSegments; s++)
         for (int k = 0; k < ppt_pkg::NumCoeffs; k++)
            for (int a = 0; a < ppt_pkg::NumAxes; a++)
               send_request(ppt_pkg::OP_WRITE, 4'(s), 3'(k), 2'(a), pick_coeff(), $urandom);

      send_request(ppt_pkg::OP_EVAL, 4'hF, 3'h7, 2'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ppt_pkg::OP_WRITE, 4'h0, 3'd6, 2'd0, 32'h1234_5678, 32'd0);
      send_request(ppt_pkg::OP_WRITE, 4'h0, 3'd7, 2'd1, 32'h1234_5678, 32'd0);
      send_request(ppt_pkg::OP_WRITE, 4'h0, 3'd0, 2'd3, 32'h1234_5678, 32'd0);
      send_request(ppt_pkg::OP_WRITE, 4'h0, 3'd5, 2'd2, 32'h7FFF_FFFF, 32'd0);
      send_request(ppt_pkg::OP_WRITE, 4'h0, 3'd4, 2'd1, 32'h8000_0000, 32'd0);
      send_request(ppt_pkg::OP_APPEND, 4'h0, 3'd0, 2'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(ppt_pkg::OP_APPEND, 4'h0, 3'd0, 2'd0, 32'd0, 32'h0001_0000);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'd0);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'h8000_0000);
      send_request(ppt_pkg::OP_CLEAR, 4'h0, 3'd0, 2'd0, 32'd0, 32'd0);
      repeat (17) send_request(ppt_pkg::OP_APPEND, 4'h0, 3'd0, 2'd0, 32'd0, 32'h0002_0000);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'h0002_0000);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'h0002_0001);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(ppt_pkg::OP_CLEAR, 4'h0, 3'd0, 2'd0, 32'd0, 32'd0);
      send_request(ppt_pkg::OP_EVAL, 4'h0, 3'd0, 2'd0, 32'd0, 32'd0);
      request_count = 0;

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 71 : (phase == 3) ? 15 : 0;
         while (request_count < (phase + 1) * 350) begin
            run_trajectory();
            if (phase == 2 && $urandom_range(19) == 0) wait_drained();
         end
      end
      wait_drained();
      repeat (300) @(posedge clock);
      if (motion_board.mismatches == 0 && motion_board.expected_samples.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
